@@ hdl/sm83af_pkg.sv @@
// Shared types and constants for the SM83 ALU and flag unit.
// Operation codes, flag bit positions and flag-word layout, DAA constants and a flag-packing function.
// No dependencies.
package sm83af_pkg;

    // Operation codes as carried on the operation field
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLC  = 5'd10,
        OP_RRC  = 5'd11,
        OP_RL   = 5'd12,
        OP_RR   = 5'd13,
        OP_SLA  = 5'd14,
        OP_SRA  = 5'd15,
        OP_SWAP = 5'd16,
        OP_SRL  = 5'd17,
        OP_BIT  = 5'd18,
        OP_RES  = 5'd19,
        OP_SET  = 5'd20,
        OP_DAA  = 5'd21,
        OP_CPL  = 5'd22,
        OP_SCF  = 5'd23,
        OP_CCF  = 5'd24,
        OP_RLCA = 5'd25,
        OP_RRCA = 5'd26,
        OP_RLA  = 5'd27,
        OP_RRA  = 5'd28
    } op_t;

    // Flag word layout: Z N H C from MSB to LSB
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // BCD correction terms for DAA
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0] DAA_LO_LIM = 4'h9;

    typedef logic [3:0] flags_t;

    function automatic flags_t pack_flags(input logic z, input logic n,
                                          input logic h, input logic c);
        flags_t f;
        f         = '0;
        f[FLAG_Z] = z;
        f[FLAG_N] = n;
        f[FLAG_H] = h;
        f[FLAG_C] = c;
        return f;
    endfunction

endpackage

@@ hdl/sm83_alu_flag_unit.sv @@
// SM83 eight-bit ALU and flag unit: input register, ALU logic, result register.
// Depends on sm83af_pkg.
//
// Takes one operation beat per cycle on the input channel while in_ready is high,
// and returns one result beat per operation on the output channel, in order.
// Throughput is one beat per clock while out_ready stays high. An accepted beat is
// held in the input register and then loaded into the result register, where it is
// presented as valid. Between the two registers sit a 9-bit adder and a 9-bit
// subtractor with their nibble carries, the DAA correction, and the shift, mask
// and selection logic. Each stage moves on as soon as the stage after it is free.
// When both stages are full, in_ready follows out_ready combinationally. Codes
// 29-31 pass operand_a and flags_in through with write_back low.
module sm83_alu_flag_unit (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] operation,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    input  logic [2:0] bit_index,
    input  logic [3:0] flags_in,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result,
    output logic [3:0] flags_out,
    output logic       write_back
);

    // input stage
    logic                     stg_valid_reg;
    logic [4:0]               op_reg;
    logic [7:0]               a_reg;
    logic [7:0]               b_reg;
    logic [2:0]               bi_reg;
    sm83af_pkg::flags_t       fl_reg;

    // output stage
    logic                     out_valid_reg;
    logic [7:0]               result_reg;
    sm83af_pkg::flags_t       flags_reg;
    logic                     wb_reg;

    logic [7:0]               result_next;
    sm83af_pkg::flags_t       flags_next;
    logic                     wb_next;

    logic                     out_load;   // result register takes a new value
    logic                     stg_load;   // input register takes a beat

    // handshake: output register frees when empty or draining
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !stg_valid_reg || out_load;
    assign stg_load = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stg_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= stg_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_load)
        begin
            op_reg <= operation;
            a_reg  <= operand_a;
            b_reg  <= operand_b;
            bi_reg <= bit_index;
            fl_reg <= flags_in;
        end
        if (out_load && stg_valid_reg)
        begin
            result_reg <= result_next;
            flags_reg  <= flags_next;
            wb_reg     <= wb_next;
        end
    end

    // ALU and flag logic
    always_comb
    begin
        logic       zi;
        logic       ni;
        logic       hi;
        logic       ci;
        logic       cin;
        logic [8:0] add9;
        logic [4:0] add5;
        logic [8:0] sub9;
        logic [4:0] sub5;
        logic [7:0] mask;
        logic [7:0] daa_adj;
        logic       daa_c;
        logic [7:0] r;
        logic       c;

        zi = fl_reg[sm83af_pkg::FLAG_Z];
        ni = fl_reg[sm83af_pkg::FLAG_N];
        hi = fl_reg[sm83af_pkg::FLAG_H];
        ci = fl_reg[sm83af_pkg::FLAG_C];

        // carry in only for ADC/SBC
        cin = ci && ((sm83af_pkg::op_t'(op_reg) == sm83af_pkg::OP_ADC) ||
                     (sm83af_pkg::op_t'(op_reg) == sm83af_pkg::OP_SBC));

        add9 = {1'b0, a_reg} + {1'b0, b_reg} + {8'd0, cin};
        add5 = {1'b0, a_reg[3:0]} + {1'b0, b_reg[3:0]} + {4'd0, cin};
        // borrow out of bit 8 / bit 4
        sub9 = {1'b0, a_reg} - {1'b0, b_reg} - {8'd0, cin};
        sub5 = {1'b0, a_reg[3:0]} - {1'b0, b_reg[3:0]} - {4'd0, cin};

        mask = 8'd1 << bi_reg;

        // DAA correction
        daa_c   = ci;
        daa_adj = 8'd0;
        if (!ni)
        begin
            if (ci || (a_reg > sm83af_pkg::DAA_HI_LIM))
            begin
                daa_adj = daa_adj | sm83af_pkg::DAA_HI_ADJ;
                daa_c   = 1'b1;
            end
            if (hi || (a_reg[3:0] > sm83af_pkg::DAA_LO_LIM))
            begin
                daa_adj = daa_adj | sm83af_pkg::DAA_LO_ADJ;
            end
        end
        else
        begin
            if (ci)
            begin
                daa_adj = daa_adj | sm83af_pkg::DAA_HI_ADJ;
            end
            if (hi)
            begin
                daa_adj = daa_adj | sm83af_pkg::DAA_LO_ADJ;
            end
        end

        r           = a_reg;
        c           = 1'b0;
        result_next = a_reg;
        flags_next  = fl_reg;
        wb_next     = 1'b1;

        unique case (sm83af_pkg::op_t'(op_reg))
            sm83af_pkg::OP_ADD, sm83af_pkg::OP_ADC:
            begin
                result_next = add9[7:0];
                flags_next  = sm83af_pkg::pack_flags(add9[7:0] == 8'd0, 1'b0,
                                                     add5[4], add9[8]);
            end
            sm83af_pkg::OP_SUB, sm83af_pkg::OP_SBC, sm83af_pkg::OP_CP:
            begin
                result_next = sub9[7:0];
                flags_next  = sm83af_pkg::pack_flags(sub9[7:0] == 8'd0, 1'b1,
                                                     sub5[4], sub9[8]);
                wb_next     = (sm83af_pkg::op_t'(op_reg) != sm83af_pkg::OP_CP);
            end
            sm83af_pkg::OP_AND:
            begin
                r           = a_reg & b_reg;
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, 1'b0, 1'b1, 1'b0);
            end
            sm83af_pkg::OP_XOR:
            begin
                r           = a_reg ^ b_reg;
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            sm83af_pkg::OP_OR:
            begin
                r           = a_reg | b_reg;
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            sm83af_pkg::OP_INC:
            begin
                r           = a_reg + 8'd1;
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, 1'b0,
                                                     a_reg[3:0] == 4'hF, ci);
            end
            sm83af_pkg::OP_DEC:
            begin
                r           = a_reg - 8'd1;
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, 1'b1,
                                                     a_reg[3:0] == 4'h0, ci);
            end
            sm83af_pkg::OP_RLC, sm83af_pkg::OP_RRC, sm83af_pkg::OP_RL,
            sm83af_pkg::OP_RR, sm83af_pkg::OP_SLA, sm83af_pkg::OP_SRA,
            sm83af_pkg::OP_SWAP, sm83af_pkg::OP_SRL:
            begin
                unique case (sm83af_pkg::op_t'(op_reg))
                    sm83af_pkg::OP_RLC:
                    begin
                        r = {a_reg[6:0], a_reg[7]};
                        c = a_reg[7];
                    end
                    sm83af_pkg::OP_RRC:
                    begin
                        r = {a_reg[0], a_reg[7:1]};
                        c = a_reg[0];
                    end
                    sm83af_pkg::OP_RL:
                    begin
                        r = {a_reg[6:0], ci};
                        c = a_reg[7];
                    end
                    sm83af_pkg::OP_RR:
                    begin
                        r = {ci, a_reg[7:1]};
                        c = a_reg[0];
                    end
                    sm83af_pkg::OP_SLA:
                    begin
                        r = {a_reg[6:0], 1'b0};
                        c = a_reg[7];
                    end
                    sm83af_pkg::OP_SRA:
                    begin
                        r = {a_reg[7], a_reg[7:1]};
                        c = a_reg[0];
                    end
                    sm83af_pkg::OP_SWAP:
                    begin
                        r = {a_reg[3:0], a_reg[7:4]};
                        c = 1'b0;
                    end
                    default:    // SRL
                    begin
                        r = {1'b0, a_reg[7:1]};
                        c = a_reg[0];
                    end
                endcase
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, 1'b0, 1'b0, c);
            end
            sm83af_pkg::OP_BIT:
            begin
                flags_next = sm83af_pkg::pack_flags((a_reg & mask) == 8'd0, 1'b0,
                                                    1'b1, ci);
                wb_next    = 1'b0;
            end
            sm83af_pkg::OP_RES:
            begin
                result_next = a_reg & ~mask;
            end
            sm83af_pkg::OP_SET:
            begin
                result_next = a_reg | mask;
            end
            sm83af_pkg::OP_DAA:
            begin
                r           = ni ? (a_reg - daa_adj) : (a_reg + daa_adj);
                result_next = r;
                flags_next  = sm83af_pkg::pack_flags(r == 8'd0, ni, 1'b0, daa_c);
            end
            sm83af_pkg::OP_CPL:
            begin
                result_next = ~a_reg;
                flags_next  = sm83af_pkg::pack_flags(zi, 1'b1, 1'b1, ci);
            end
            sm83af_pkg::OP_SCF:
            begin
                flags_next = sm83af_pkg::pack_flags(zi, 1'b0, 1'b0, 1'b1);
            end
            sm83af_pkg::OP_CCF:
            begin
                flags_next = sm83af_pkg::pack_flags(zi, 1'b0, 1'b0, !ci);
            end
            // accumulator rotates always clear Z
            sm83af_pkg::OP_RLCA:
            begin
                result_next = {a_reg[6:0], a_reg[7]};
                flags_next  = sm83af_pkg::pack_flags(1'b0, 1'b0, 1'b0, a_reg[7]);
            end
            sm83af_pkg::OP_RRCA:
            begin
                result_next = {a_reg[0], a_reg[7:1]};
                flags_next  = sm83af_pkg::pack_flags(1'b0, 1'b0, 1'b0, a_reg[0]);
            end
            sm83af_pkg::OP_RLA:
            begin
                result_next = {a_reg[6:0], ci};
                flags_next  = sm83af_pkg::pack_flags(1'b0, 1'b0, 1'b0, a_reg[7]);
            end
            sm83af_pkg::OP_RRA:
            begin
                result_next = {ci, a_reg[7:1]};
                flags_next  = sm83af_pkg::pack_flags(1'b0, 1'b0, 1'b0, a_reg[0]);
            end
            default:    // unused codes: pass through, no write-back
            begin
                result_next = a_reg;
                flags_next  = fl_reg;
                wb_next     = 1'b0;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign result     = result_reg;
    assign flags_out  = flags_reg;
    assign write_back = wb_reg;

    // a full input stage behind a stalled result must block the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are held");

    // a beat in the input stage moves to the output when it is free
    a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && out_load) |=> out_valid_reg)
        else $error("beat lost between input and result stage");

    // compare never writes back
    a_cp_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && out_load &&
         (sm83af_pkg::op_t'(op_reg) == sm83af_pkg::OP_CP)) |=> !wb_reg)
        else $error("CP produced a write-back");

endmodule
